// ===== rtl/rrts_pkg.sv =====
// ---------------------------------------------------------------------------
// rrts_pkg: shared types and constants for the round-robin task scheduler
// Holds opcode codes, field widths and the cell control struct.
// ---------------------------------------------------------------------------
package rrts_pkg;

	localparam int TASK_SLOTS_DEF = 16;
	localparam int SLICE_W = 16;
	localparam int PERIOD_W = 10;
	localparam int MS_W = 32;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_ADMIT = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK = 2'd1;
	localparam logic [OP_W-1:0] OP_YIELD = 2'd2;
	localparam logic [OP_W-1:0] OP_SLEEP = 2'd3;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TICK,
		ST_WAKE,
		ST_OUT
	} state_t;

	// Broadcast command to every sleep cell.
	typedef struct packed {
		logic count; // count down on a tick
		logic load;  // start sleeping
	} cell_cmd_t;

endpackage

// ===== rtl/rrts_sleep_cell.sv =====
// ---------------------------------------------------------------------------
// rrts_sleep_cell: one task's sleep countdown
// Counts down on a tick and raises wake when the count expires. The wake
// request travels down the chain so the lowest waking task is served first.
// ---------------------------------------------------------------------------
module rrts_sleep_cell
	import rrts_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cell_cmd_t       cmd,
	input  logic            sel,
	input  logic [MS_W-1:0] load_val,
	input  logic            ack,
	input  logic            wake_in,
	output logic            wake_out,
	output logic            wake_here,
	output logic            sleeping
);

	logic            sleeping_q;
	logic            pend_q;
	logic [MS_W-1:0] left_q;

	assign sleeping = sleeping_q;
	// This cell takes the wake slot only if no lower cell has claimed it.
	assign wake_here = pend_q && !wake_in;
	assign wake_out = pend_q || wake_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleeping_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (cmd.load && sel) begin
			sleeping_q <= 1'b1;
		end else if (cmd.count && sleeping_q && left_q <= 1) begin
			sleeping_q <= 1'b0;
			pend_q <= 1'b1;
		end else if (ack && wake_here) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && sel) begin
			left_q <= load_val;
		end else if (cmd.count && sleeping_q && left_q > 1) begin
			left_q <= left_q - 1'b1;
		end
	end

endmodule

// ===== rtl/rrts_divider.sv =====
// ---------------------------------------------------------------------------
// rrts_divider: ceiling divide of a millisecond count by the tick period
// Restoring division, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rrts_divider
	import rrts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MS_W-1:0]     dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic                done,
	output logic [MS_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(MS_W + 1);

	logic [MS_W-1:0]     num_q;
	logic [PERIOD_W:0]   rem_q;
	logic [PERIOD_W-1:0] div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [PERIOD_W:0]   trial;
	logic                ge;

	assign trial = {rem_q[PERIOD_W-1:0], num_q[MS_W-1]};
	assign ge = trial >= {1'b0, div_q};
	assign done = done_q;
	// Rounding up: one more whenever a remainder is left.
	assign quotient = num_q + {{(MS_W-1){1'b0}}, (rem_q != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MS_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= (divisor == '0) ? PERIOD_W'(1) : divisor;
		end else if (busy_q) begin
			num_q <= {num_q[MS_W-2:0], ge};
			rem_q <= ge ? trial - {1'b0, div_q} : trial;
		end
	end

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// round_robin_task_scheduler: round-robin scheduler with slices and sleep
// Ready queue, running task, per-task slices and a chain of sleep cells.
// ---------------------------------------------------------------------------
// Usage: each input transaction (opcode, task_number, sleep_ms) is one
// scheduler event: admit, tick, yield or sleep. Exactly one output
// transaction follows each input, carrying the running task (TASK_SLOTS
// means idle), a switch flag, the ready count and a reject status.
// Steps after the accepting edge: admit and yield go straight to the output
// state. A tick counts down the sleep cells, then serves each task that
// wakes, one by one; the wake scan walks the chain of sleep cells, lowest
// task first. A sleep waits in the divide state for the bit-serial ceiling
// divider (one quotient bit a cycle), but not when the idle task is running.
// One transaction is in flight at a time; ready stays low until its result
// has been delivered.
// Reset clears the queue, marks the idle task as running, wakes no one and
// loads the configuration registers with 10 ticks and 10 ms.
// When the receiver stalls, the result is held in the output register and
// no new transaction is taken until it is delivered.
// Configuration writes: index 0 is slice_length, index 1 tick_period_ms.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler
	import rrts_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [3:0]           task_number,
	input  logic [MS_W-1:0]      sleep_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [4:0]           running_task,
	output logic                 switched,
	output logic [4:0]           ready_total,
	output logic                 status,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [SLICE_W-1:0]   cfg_data
);

	localparam int TW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);

	// Configuration registers.
	logic [SLICE_W-1:0]  slice_len_q;
	logic [PERIOD_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_len_q <= SLICE_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				slice_len_q <= cfg_data;
			end else begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end
		end
	end

	// Ready queue as a shift register: entry 0 is the head.
	logic [TW-1:0]       queue_q [TASK_SLOTS];
	logic [CW-1:0]       count_q;
	logic [SLICE_W-1:0]  slice_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] queued_q;
	logic [TW-1:0]       queue_d [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] queued_d;

	state_t              state_q, state_d;
	logic [OP_W-1:0]     op_q;
	logic [3:0]          tn_q;
	logic [4:0]          prev_q;
	logic                reject_q;

	logic                out_valid_q;
	logic [4:0]          run_q;
	logic                sw_q;
	logic [4:0]          total_q;
	logic                status_q;

	logic                idle;
	logic [TW-1:0]       head;
	logic                admit_ok;
	logic                in_go;

	// Result as it stands after this transaction's queue update.
	logic [4:0]          run_now;
	logic [CW-1:0]       count_after;

	// Sleep cell chain.
	cell_cmd_t             cmd;
	logic [TASK_SLOTS-1:0] sel;
	logic [TASK_SLOTS:0]   wake_chain;
	logic [TASK_SLOTS-1:0] wake_here;
	logic [TASK_SLOTS-1:0] sleeping;
	logic                  wake_ack;
	logic [TW-1:0]         wake_task;

	// Divider.
	logic                div_start;
	logic                div_done;
	logic [MS_W-1:0]     ticks;

	assign in_go = in_valid && in_ready;
	assign idle = (count_q == '0);
	assign head = queue_q[0];
	assign admit_ok = ({1'b0, tn_q} < 5'(TASK_SLOTS)) && !sleeping[TW'(tn_q)]
		&& !queued_q[TW'(tn_q)];

	assign wake_chain[0] = 1'b0;
	genvar g;
	generate
		for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
			assign sel[g] = (head == TW'(g));
			rrts_sleep_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.sel      (sel[g]),
				.load_val (ticks),
				.ack      (wake_ack),
				.wake_in  (wake_chain[g]),
				.wake_out (wake_chain[g+1]),
				.wake_here(wake_here[g]),
				.sleeping (sleeping[g])
			);
		end
	endgenerate

	// Encode the serviced wake request.
	always_comb begin
		wake_task = '0;
		for (int k = 0; k < TASK_SLOTS; k++) begin
			if (wake_here[k]) begin
				wake_task = TW'(k);
			end
		end
	end

	// The divider loads the request straight from the input port at the
	// accepting edge.
	rrts_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sleep_ms),
		.divisor (period_q),
		.done    (div_done),
		.quotient(ticks)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_go) begin
					case (opcode)
						OP_TICK:  state_d = ST_TICK;
						OP_SLEEP: state_d = ST_DIV;
						default:  state_d = ST_OUT;
					endcase
				end
			end
			ST_DIV:  if (div_done || idle) state_d = ST_OUT;
			ST_TICK: state_d = ST_WAKE;
			ST_WAKE: if (!wake_chain[TASK_SLOTS]) state_d = ST_OUT;
			ST_OUT:  if (!out_valid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		wake_ack = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q;
				div_start = in_go && (opcode == OP_SLEEP);
			end
			ST_DIV:  cmd.load = div_done && !idle && (ticks != '0);
			ST_TICK: cmd.count = 1'b1;
			ST_WAKE: wake_ack = wake_chain[TASK_SLOTS];
			default: ;
		endcase
	end

	// Queue operations.
	logic            do_push, do_pop;
	logic [TW-1:0]   push_val;
	logic            slice_exp;

	assign slice_exp = slice_q[head] <= 1;

	always_comb begin
		do_push = 1'b0;
		do_pop = 1'b0;
		push_val = head;
		case (state_q)
			ST_OUT: begin
				if (state_d == ST_IDLE) begin
					case (op_q)
						OP_ADMIT: begin
							do_push = admit_ok;
							push_val = TW'(tn_q);
						end
						OP_YIELD: begin
							do_pop = count_q > CW'(1);
							do_push = do_pop;
						end
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done && !idle) begin
					do_pop = 1'b1;
					do_push = (ticks == '0);
				end
			end
			ST_TICK: begin
				do_pop = !idle && slice_exp;
				do_push = do_pop;
			end
			ST_WAKE: begin
				do_push = wake_chain[TASK_SLOTS];
				push_val = wake_task;
			end
			default: ;
		endcase
	end

	// Queue contents after a pop, a push or a rotation.
	logic [CW-1:0] tail;
	assign tail = do_pop ? count_q - 1'b1 : count_q;

	always_comb begin
		queued_d = queued_q;
		if (do_pop) queued_d[head] = 1'b0;
		if (do_push) queued_d[push_val] = 1'b1;
	end

	always_comb begin
		for (int k = 0; k < TASK_SLOTS; k++) begin
			queue_d[k] = queue_q[k];
		end
		if (do_pop) begin
			for (int k = 0; k < TASK_SLOTS - 1; k++) begin
				queue_d[k] = queue_q[k+1];
			end
		end
		for (int k = 0; k < TASK_SLOTS; k++) begin
			if (do_push && CW'(k) == tail) begin
				queue_d[k] = push_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			queued_q <= '0;
			out_valid_q <= 1'b0;
			prev_q <= 5'(TASK_SLOTS);
		end else begin
			state_q <= state_d;
			if (do_pop && !do_push) count_q <= count_q - 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			queued_q <= queued_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_OUT && !out_valid_q) begin
				out_valid_q <= 1'b1;
				prev_q <= run_now;
			end
		end
	end

	// Queue contents and slices.
	always_ff @(posedge clk) begin
		for (int k = 0; k < TASK_SLOTS; k++) begin
			queue_q[k] <= queue_d[k];
		end
		if (state_q == ST_OUT && state_d == ST_IDLE && op_q == OP_ADMIT && admit_ok)
		begin
			slice_q[TW'(tn_q)] <= slice_len_q;
		end
		if (state_q == ST_TICK && !idle) begin
			slice_q[head] <= slice_exp ? slice_len_q : slice_q[head] - 1'b1;
		end
		if (in_go) begin
			op_q <= opcode;
			tn_q <= task_number;
		end
		if (state_q == ST_OUT && !out_valid_q) begin
			run_q <= run_now;
			sw_q <= run_now != prev_q;
			total_q <= 5'(count_after);
			status_q <= (op_q == OP_ADMIT) && !admit_ok;
		end
	end

	// Admit and yield update the queue at the same edge that loads the
	// result, so their effect on the head is looked ahead here.
	assign count_after = (op_q == OP_ADMIT && admit_ok) ? count_q + 1'b1 : count_q;
	always_comb begin
		if (op_q == OP_ADMIT && admit_ok && idle) begin
			run_now = 5'(tn_q);
		end else if (idle) begin
			run_now = 5'(TASK_SLOTS);
		end else if (op_q == OP_YIELD && count_q > CW'(1)) begin
			run_now = 5'(queue_q[1]);
		end else begin
			run_now = 5'(head);
		end
	end

	assign reject_q = 1'b0;
	assign out_valid = out_valid_q;
	assign running_task = run_q;
	assign switched = sw_q;
	assign ready_total = total_q;
	assign status = status_q | reject_q;

endmodule
